@@ rtl/mau_pkg.sv @@
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;

    localparam int RES_W        = 31;
    localparam int WIDE_W       = 64;
    localparam int OP_W         = 3;
    localparam int STEP_BITS_DF = 4;
    localparam logic [RES_W-1:0] MODULUS_RST = RES_W'(7);

    typedef enum logic [OP_W-1:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_NEG    = 3'd4
    } t_op;

    // One beat in the remainder pipeline.
    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [RES_W-1:0]  rem;
        logic [WIDE_W-1:0] dvd;
    } t_div;

endpackage

@@ rtl/modular_arithmetic_unit.sv @@
// Top level: pipelined modular add, subtract, multiply, negate and reduce.
// Beats pass operand, intermediate and sign registers, remainder stages, output register.
// Throughput: one beat per cycle unless i_ready stalls the output; the remainder
// pipeline retires STEP_BITS dividend bits per stage, one compare-subtract each, and each
// stage stalls only when full. Reset clears every valid bit and loads the modulus with 7.
module modular_arithmetic_unit #(
    parameter int STEP_BITS = mau_pkg::STEP_BITS_DF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mau_pkg::RES_W-1:0]  i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mau_pkg::OP_W-1:0]   i_opcode,
    input  logic signed [mau_pkg::WIDE_W-1:0] i_wide_value,
    input  logic [mau_pkg::RES_W-1:0]  i_left_residue,
    input  logic [mau_pkg::RES_W-1:0]  i_right_residue,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mau_pkg::RES_W-1:0]  o_residue
);
    import mau_pkg::*;

    localparam int NSTAGE = WIDE_W / STEP_BITS;

    logic [RES_W-1:0] r_modulus;

    // stage 1: capture operands
    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic [WIDE_W-1:0] r_s1_wide;
    logic [RES_W-1:0]  r_s1_left;
    logic [RES_W-1:0]  r_s1_right;
    logic              w_s1_ready;

    // stage 2: exact signed intermediate
    logic              r_s2_valid;
    logic [WIDE_W-1:0] r_s2_val;
    logic              r_s2_zero;
    logic [WIDE_W-1:0] n_s2_val;
    logic              n_s2_zero;
    logic              w_s2_ready;
    logic [2*RES_W-1:0] w_s2_prod;

    // stage 3: sign and magnitude
    logic              r_s3_valid;
    t_div              r_s3_data;
    logic              w_s3_ready;

    logic              w_valid [NSTAGE+1];
    t_div              w_data  [NSTAGE+1];
    logic              w_ready [NSTAGE+1];

    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_res;
    logic [RES_W-1:0]  n_out_res;
    logic              w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RST;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    assign o_ready = w_s1_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_s2_ready = !r_s2_valid || w_s3_ready;
    assign w_s3_ready = !r_s3_valid || w_ready[0];
    assign w_out_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1_op    <= i_opcode;
            r_s1_wide  <= i_wide_value;
            r_s1_left  <= i_left_residue;
            r_s1_right <= i_right_residue;
        end
    end

    // residue operands multiply at the full 2*RES_W product width
    assign w_s2_prod = r_s1_left * r_s1_right;

    always_comb begin
        n_s2_zero = (r_modulus == '0);
        unique case (r_s1_op)
            OP_REDUCE: n_s2_val = r_s1_wide;
            OP_ADD:    n_s2_val = WIDE_W'(r_s1_left) + WIDE_W'(r_s1_right);
            OP_SUB:    n_s2_val = WIDE_W'(r_s1_left) - WIDE_W'(r_s1_right);
            OP_MUL:    n_s2_val = WIDE_W'(w_s2_prod);
            OP_NEG:    n_s2_val = '0 - WIDE_W'(r_s1_left);
            default: begin
                n_s2_val  = '0;
                n_s2_zero = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_val  <= n_s2_val;
            r_s2_zero <= n_s2_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    // truncating remainder works on the magnitude; sign fixes up at the end
    always_ff @(posedge i_clk) begin
        if (w_s3_ready && r_s2_valid) begin
            r_s3_data.neg  <= r_s2_val[WIDE_W-1];
            r_s3_data.zero <= r_s2_zero;
            r_s3_data.rem  <= '0;
            r_s3_data.dvd  <= r_s2_val[WIDE_W-1] ? ('0 - r_s2_val) : r_s2_val;
        end
    end

    assign w_valid[0] = r_s3_valid;
    assign w_data[0]  = r_s3_data;
    assign w_ready[NSTAGE] = w_out_ready;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_div
        mau_div_stage #(
            .STEP_BITS (STEP_BITS)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_modulus (r_modulus),
            .i_valid   (w_valid[g]),
            .i_data    (w_data[g]),
            .o_ready   (w_ready[g]),
            .o_valid   (w_valid[g+1]),
            .o_data    (w_data[g+1]),
            .i_ready   (w_ready[g+1])
        );
    end

    always_comb begin
        priority if (w_data[NSTAGE].zero) begin
            n_out_res = '0;
        end else if (w_data[NSTAGE].neg && (w_data[NSTAGE].rem != '0)) begin
            n_out_res = r_modulus - w_data[NSTAGE].rem;
        end else begin
            n_out_res = w_data[NSTAGE].rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[NSTAGE]) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_residue = r_out_res;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_modulus != '0) |-> r_out_res < r_modulus)
        else $error("residue not below modulus");
    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_modulus == '0) |-> r_out_res == '0)
        else $error("nonzero residue with zero modulus");
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_out_valid && !i_ready)
        else $error("input stalled with room in the pipeline");

endmodule

@@ rtl/mau_div_stage.sv @@
// One registered stage of the restoring remainder pipeline.
module mau_div_stage #(
    parameter int STEP_BITS = mau_pkg::STEP_BITS_DF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mau_pkg::RES_W-1:0] i_modulus,
    input  logic                     i_valid,
    input  mau_pkg::t_div            i_data,
    output logic                     o_ready,
    output logic                     o_valid,
    output mau_pkg::t_div            o_data,
    input  logic                     i_ready
);
    import mau_pkg::*;

    logic         r_valid;
    t_div         r_data;
    t_div         n_data;
    logic [RES_W:0] w_trial [STEP_BITS];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < STEP_BITS; k++) begin
            w_trial[k] = {n_data.rem, n_data.dvd[WIDE_W-1]};
            n_data.dvd = {n_data.dvd[WIDE_W-2:0], 1'b0};
            if (w_trial[k] >= {1'b0, i_modulus}) begin
                n_data.rem = RES_W'(w_trial[k] - {1'b0, i_modulus});
            end else begin
                n_data.rem = w_trial[k][RES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data))
        else $error("stage lost a stalled beat");
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.zero |-> r_data.rem < i_modulus)
        else $error("partial remainder not below modulus");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("stage valid survived reset");

endmodule
